// ===== design/twm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twm_pkg
// Shared constants, status codes and controller/datapath structs for the
// trie signature window matcher.
// ----------------------------------------------------------------------------
package twm_pkg;

  localparam int MAX_LEN  = 32;
  localparam int NODES    = 1024;
  localparam int NODE_W   = $clog2(NODES);
  localparam int USED_W   = $clog2(NODES + 1);
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int WIN_W    = $clog2(MAX_LEN);

  // Item kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_SCAN  = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  // Scan phases
  localparam logic [1:0] PH_PREFILL = 2'd0;
  localparam logic [1:0] PH_RUN     = 2'd1;
  localparam logic [1:0] PH_STOP    = 2'd2;

  // Stop modes
  localparam logic [1:0] MODE_WHOLE = 2'd0;
  localparam logic [1:0] MODE_SCAN  = 2'd1;

  // Result status codes
  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_PARTIAL   = 3'd1;
  localparam logic [2:0] ST_HIT       = 3'd2;
  localparam logic [2:0] ST_STOP_SCAN = 3'd3;
  localparam logic [2:0] ST_STOP_EXIT = 3'd4;
  localparam logic [2:0] ST_STORED    = 3'd5;
  localparam logic [2:0] ST_FAULT     = 3'd6;

  typedef struct packed {
    logic load;        // capture the accepted item
    logic add_fault;   // answer the pattern byte with a fault
    logic walk_start;  // begin a sibling walk
    logic rd;          // read the node at the walk cursor
    logic step_sib;    // move to the next sibling
    logic add_hit;     // reuse the matched node
    logic add_new;     // write a new node
    logic add_link;    // link the new node in
    logic srch_init;   // start a window search
    logic srch_hit;    // search advanced to the matched node
    logic srch_miss;   // search failed
    logic none_res;    // no-match result without a search
    logic go_run;      // enter the running phase
    logic fill;        // store a prefill byte
    logic shift;       // shift the window
    logic flush_init;  // load the flush counter
    logic emit;        // load the output register
    logic emit_last;
    logic clear;       // clear the stream state
  } twm_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       pattern_end;
    logic [1:0] phase;
    logic       longest_zero;
    logic       add_blocked;
    logic       fill_reached;
    logic       fill_zero;
    logic       cnt_zero;
    logic       srch_done;
    logic       cur_zero;
    logic       byte_match;
    logic       store_full;
    logic       rd_has_id;
    logic       res_stop;
    logic       slot_free;
  } twm_sts_t;

endpackage

// ===== design/twm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twm channel interfaces
// Valid/ready channels for items, results and the stop mode register.
// ----------------------------------------------------------------------------
interface twm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic        pattern_end;
  logic [15:0] pattern_id;
  modport source (output valid, kind, byte_value, pattern_end, pattern_id, input ready);
  modport sink   (input valid, kind, byte_value, pattern_end, pattern_id, output ready);
endinterface

interface twm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] matched_id;
  logic        last;
  modport source (output valid, status, matched_id, last, input ready);
  modport sink   (input valid, status, matched_id, last, output ready);
endinterface

interface twm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== design/trie_signature_window_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_signature_window_matcher
// Byte trie of signature patterns with a sliding window search.
// ----------------------------------------------------------------------------
// Use: items arrive on in_ch (kind, byte_value, pattern_end, pattern_id);
// kind 0 adds one pattern byte, kind 1 scans one stream byte, kind 2 ends
// the stream. Results leave on out_ch (status, matched_id, last), with last
// set on the final result of an item; some items give none. cfg_ch writes
// the two-bit stop mode, which must be written only between items; the block
// does not enforce this. One item is processed at a time; in_ch.ready is
// high while the sequencer is idle. An add walks the siblings in the node
// memory; a search walks the window bytes, bounded by the window length (at
// most 32 bytes), and every node visit is one registered read of the single
// node memory port. A flush repeats that search once per held byte.
// Reset is synchronous: the trie is emptied, the window cleared and the stop
// mode returns to whole-stream scanning. No clearing pass is needed.
// The output register holds a result until out_ch.ready; the sequencer
// waits while a new result has no free slot.
// ----------------------------------------------------------------------------
module trie_signature_window_matcher import twm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  twm_in_if.sink     in_ch,
  twm_out_if.source  out_ch,
  twm_cfg_if.sink    cfg_ch
);

  twm_cmd_t cmd;
  twm_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  twm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  twm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_ch.kind),
    .in_byte    (in_ch.byte_value),
    .in_end     (in_ch.pattern_end),
    .in_id      (in_ch.pattern_id),
    .cfg_we     (cfg_ch.valid),
    .cfg_data   (cfg_ch.data),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_id     (out_ch.matched_id),
    .out_last   (out_ch.last)
  );

  // One item at a time: ready drops after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  // Insert results always close their item
  a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_STORED || out_ch.status == ST_FAULT)
      |-> out_ch.last)
    else $error("insert result without last");

  // A stop always ends the item
  a_stop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_STOP_SCAN || out_ch.status == ST_STOP_EXIT)
      |-> out_ch.last)
    else $error("stop result without last");

  // Only hit and stop results carry an id
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_HIT && out_ch.status != ST_STOP_SCAN &&
      out_ch.status != ST_STOP_EXIT |-> out_ch.matched_id == 16'd0)
    else $error("id on a non-hit result");

endmodule

// ===== design/twm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twm_ctrl
// Sequencer: dispatches items, runs node walks and hands results out.
// ----------------------------------------------------------------------------
module twm_ctrl import twm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  twm_sts_t sts,
  output twm_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_FILLED = 4'd2;
  localparam logic [3:0] S_FSHIFT = 4'd3;
  localparam logic [3:0] S_SSTART = 4'd4;
  localparam logic [3:0] S_SSTEP  = 4'd5;
  localparam logic [3:0] S_WRD    = 4'd6;
  localparam logic [3:0] S_WCK    = 4'd7;
  localparam logic [3:0] S_ALINK  = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       is_add;
  logic       last_res;

  assign in_ready = (state_r == S_IDLE);
  assign is_add   = (sts.kind == KIND_ADD);
  assign last_res = (sts.kind != KIND_FLUSH) || sts.res_stop || sts.cnt_zero;

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        priority if (sts.kind == KIND_ADD) begin
          if (sts.add_blocked) begin
            cmd.add_fault = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            cmd.walk_start = 1'b1;
            state_nxt      = S_WRD;
          end
        end else if (sts.kind == KIND_SCAN) begin
          priority if (sts.phase == PH_PREFILL) begin
            if (sts.longest_zero) begin
              cmd.none_res = 1'b1;
              cmd.go_run   = 1'b1;
              state_nxt    = S_EMIT;
            end else begin
              cmd.fill  = 1'b1;
              state_nxt = S_FILLED;
            end
          end else if (sts.phase == PH_RUN) begin
            cmd.shift = 1'b1;
            state_nxt = S_SSTART;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (sts.kind == KIND_FLUSH) begin
          priority if (sts.phase == PH_STOP) begin
            cmd.clear = 1'b1;
          end else if (sts.phase == PH_PREFILL) begin
            cmd.flush_init = 1'b1;
            state_nxt      = S_SSTART;
          end else if (sts.fill_zero) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.flush_init = 1'b1;
            state_nxt      = S_FSHIFT;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FILLED: begin
        if (sts.fill_reached) begin
          cmd.go_run = 1'b1;
          state_nxt  = S_SSTART;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FSHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = S_SSTART;
      end
      S_SSTART: begin
        cmd.srch_init = 1'b1;
        state_nxt     = S_SSTEP;
      end
      S_SSTEP: begin
        if (sts.srch_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_WRD;
        end
      end
      S_WRD: begin
        priority if (!sts.cur_zero) begin
          cmd.rd    = 1'b1;
          state_nxt = S_WCK;
        end else if (!is_add) begin
          cmd.srch_miss = 1'b1;
          state_nxt     = S_EMIT;
        end else if (sts.store_full) begin
          cmd.add_fault = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          cmd.add_new = 1'b1;
          state_nxt   = S_ALINK;
        end
      end
      S_WCK: begin
        priority if (!sts.byte_match) begin
          cmd.step_sib = 1'b1;
          state_nxt    = S_WRD;
        end else if (is_add) begin
          cmd.add_hit = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          cmd.srch_hit = 1'b1;
          state_nxt    = sts.rd_has_id ? S_EMIT : S_SSTEP;
        end
      end
      S_ALINK: begin
        cmd.add_link = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = last_res;
          // Flush continues with one zero shift per held byte
          priority if (sts.kind != KIND_FLUSH) begin
            state_nxt = S_IDLE;
          end else if (last_res) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.shift = 1'b1;
            state_nxt = S_SSTART;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/twm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twm_dp
// Datapath: node memories, insert cursor, scan window, search registers and
// the output register.
// ----------------------------------------------------------------------------
module twm_dp import twm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  twm_cmd_t    cmd,
  output twm_sts_t    sts,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_byte,
  input  logic        in_end,
  input  logic [15:0] in_id,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_id,
  output logic        out_last
);

  // Node memories
  logic [7:0]        mem_byte  [NODES];
  logic [NODE_W-1:0] mem_child [NODES];
  logic [NODE_W-1:0] mem_sib   [NODES];
  logic              mem_has   [NODES];
  logic [15:0]       mem_id    [NODES];

  logic [7:0]        rd_byte_r;
  logic [NODE_W-1:0] rd_child_r;
  logic [NODE_W-1:0] rd_sib_r;
  logic              rd_has_r;
  logic [15:0]       rd_id_r;

  // Item registers
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic        end_r;
  logic [15:0] id_r;

  // Trie and stream state
  logic [NODE_W-1:0] root_child_r;
  logic [NODE_W-1:0] cursor_r;
  logic [NODE_W-1:0] cursor_child_r;
  logic [USED_W-1:0] nodes_used_r;
  logic [LEN_W-1:0]  plen_r;
  logic [LEN_W-1:0]  longest_r;
  logic              rejected_r;
  logic [7:0]        window_r [MAX_LEN];
  logic [LEN_W-1:0]  fill_r;
  logic [1:0]        phase_r;
  logic [1:0]        mode_r;
  logic [LEN_W-1:0]  cnt_r;

  // Walk and search state
  logic [NODE_W-1:0] cur_r;
  logic [NODE_W-1:0] prev_r;
  logic [NODE_W-1:0] new_r;
  logic [NODE_W-1:0] srch_child_r;
  logic [7:0]        key_r;
  logic [LEN_W-1:0]  idx_r;
  logic [2:0]        res_st_r;
  logic [15:0]       res_id_r;

  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [15:0]       out_id_r;
  logic              out_last_r;

  logic              is_add;
  logic [7:0]        shift_val;
  logic [7:0]        win_cur;
  logic [LEN_W-1:0]  plen_inc;
  logic [2:0]        hit_st;
  logic              link_root;
  logic [NODE_W-1:0] root_child_upd;

  assign is_add    = (kind_r == KIND_ADD);
  assign shift_val = (kind_r == KIND_SCAN) ? byte_r : 8'd0;
  assign win_cur   = window_r[idx_r[WIN_W-1:0]];
  assign plen_inc  = plen_r + LEN_W'(1);
  assign hit_st    = (mode_r == MODE_WHOLE) ? ST_HIT :
                     (mode_r == MODE_SCAN) ? ST_STOP_SCAN : ST_STOP_EXIT;
  assign link_root = cmd.add_link && (prev_r == '0) && (cursor_r == '0);
  assign root_child_upd = link_root ? new_r : root_child_r;

  // Status to the sequencer
  always_comb begin
    sts.kind         = kind_r;
    sts.pattern_end  = end_r;
    sts.phase        = phase_r;
    sts.longest_zero = (longest_r == '0);
    sts.add_blocked  = rejected_r || (plen_r >= LEN_W'(MAX_LEN));
    sts.fill_reached = (fill_r >= longest_r);
    sts.fill_zero    = (fill_r == '0);
    sts.cnt_zero     = (cnt_r == '0);
    sts.srch_done    = (idx_r >= longest_r) || (win_cur == 8'd0);
    sts.cur_zero     = (cur_r == '0);
    sts.byte_match   = (rd_byte_r == key_r);
    sts.store_full   = (nodes_used_r >= USED_W'(NODES));
    sts.rd_has_id    = rd_has_r;
    sts.res_stop     = (res_st_r == ST_STOP_SCAN) || (res_st_r == ST_STOP_EXIT);
    sts.slot_free    = !out_valid_r || out_ready;
  end

  // Node memory read port
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_byte_r  <= mem_byte[cur_r];
      rd_child_r <= mem_child[cur_r];
      rd_sib_r   <= mem_sib[cur_r];
      rd_has_r   <= mem_has[cur_r];
      rd_id_r    <= mem_id[cur_r];
    end
  end

  // Node memory writes
  always_ff @(posedge clk) begin
    if (cmd.add_new) begin
      mem_byte[nodes_used_r[NODE_W-1:0]] <= byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_new) begin
      mem_has[nodes_used_r[NODE_W-1:0]] <= end_r;
      mem_id[nodes_used_r[NODE_W-1:0]]  <= end_r ? id_r : 16'd0;
    end else if (cmd.add_hit && end_r && !rd_has_r) begin
      mem_has[cur_r] <= 1'b1;
      mem_id[cur_r]  <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_new) begin
      mem_child[nodes_used_r[NODE_W-1:0]] <= '0;
    end else if (cmd.add_link && (prev_r == '0) && (cursor_r != '0)) begin
      mem_child[cursor_r] <= new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_new) begin
      mem_sib[nodes_used_r[NODE_W-1:0]] <= '0;
    end else if (cmd.add_link && (prev_r != '0)) begin
      mem_sib[prev_r] <= new_r;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      byte_r <= in_byte;
      end_r  <= in_end;
      id_r   <= in_id;
    end
  end

  // Walk, search and result registers
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      cur_r  <= is_add ? cursor_child_r : srch_child_r;
      prev_r <= '0;
      key_r  <= is_add ? byte_r : win_cur;
    end else if (cmd.step_sib) begin
      prev_r <= cur_r;
      cur_r  <= rd_sib_r;
    end
    if (cmd.add_new) begin
      new_r <= nodes_used_r[NODE_W-1:0];
    end
    if (cmd.srch_init) begin
      idx_r        <= '0;
      srch_child_r <= root_child_r;
      res_st_r     <= ST_NONE;
      res_id_r     <= 16'd0;
    end
    if (cmd.srch_hit) begin
      srch_child_r <= rd_child_r;
      if (rd_has_r) begin
        res_st_r <= hit_st;
        res_id_r <= rd_id_r;
      end else begin
        res_st_r <= ST_PARTIAL;
        idx_r    <= idx_r + LEN_W'(1);
      end
    end
    if (cmd.srch_miss || cmd.none_res) begin
      res_st_r <= ST_NONE;
      res_id_r <= 16'd0;
    end
    if (cmd.add_fault) begin
      res_st_r <= ST_FAULT;
      res_id_r <= 16'd0;
    end
    if (cmd.add_hit || cmd.add_link) begin
      res_st_r <= ST_STORED;
      res_id_r <= 16'd0;
    end
  end

  // Trie insert state and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_child_r   <= '0;
      cursor_r       <= '0;
      cursor_child_r <= '0;
      nodes_used_r   <= USED_W'(1);
      plen_r         <= '0;
      longest_r      <= '0;
      rejected_r     <= 1'b0;
      fill_r         <= '0;
      phase_r        <= PH_PREFILL;
      mode_r         <= MODE_WHOLE;
      cnt_r          <= '0;
      for (int j = 0; j < MAX_LEN; j++) begin
        window_r[j] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_data;
      end
      // Pattern insertion
      if (cmd.add_new) begin
        nodes_used_r <= nodes_used_r + USED_W'(1);
      end
      if (link_root) begin
        root_child_r <= new_r;
      end
      if (cmd.add_hit) begin
        cursor_r       <= cur_r;
        cursor_child_r <= rd_child_r;
        plen_r         <= plen_inc;
      end
      if (cmd.add_link) begin
        cursor_r       <= new_r;
        cursor_child_r <= '0;
        plen_r         <= plen_inc;
      end
      if (cmd.add_fault) begin
        rejected_r <= 1'b1;
      end
      // Close the pattern on its last byte
      if ((cmd.add_hit || cmd.add_link || cmd.add_fault) && end_r) begin
        if (cmd.add_fault) begin
          if (plen_r > longest_r) longest_r <= plen_r;
        end else begin
          if (plen_inc > longest_r) longest_r <= plen_inc;
        end
        cursor_r       <= '0;
        cursor_child_r <= root_child_upd;
        plen_r         <= '0;
        rejected_r     <= 1'b0;
      end
      // Stream window
      if (cmd.fill) begin
        window_r[fill_r[WIN_W-1:0]] <= byte_r;
        fill_r                      <= fill_r + LEN_W'(1);
      end
      if (cmd.shift) begin
        for (int j = 0; j < MAX_LEN; j++) begin
          if (LEN_W'(j) + LEN_W'(1) == longest_r) begin
            window_r[j] <= shift_val;
          end else if ((j < MAX_LEN - 1) && (LEN_W'(j) + LEN_W'(1) < longest_r)) begin
            window_r[j] <= window_r[(j < MAX_LEN - 1) ? j + 1 : j];
          end
        end
        if (kind_r == KIND_FLUSH) begin
          cnt_r <= cnt_r - LEN_W'(1);
        end
      end
      if (cmd.flush_init) begin
        cnt_r <= fill_r;
      end
      if (cmd.go_run) begin
        phase_r <= PH_RUN;
      end
      if (cmd.emit && sts.res_stop) begin
        phase_r <= PH_STOP;
      end
      if (cmd.clear) begin
        fill_r  <= '0;
        phase_r <= PH_PREFILL;
        for (int j = 0; j < MAX_LEN; j++) begin
          window_r[j] <= 8'd0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_st_r;
      out_id_r     <= res_id_r;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_last   = out_last_r;

endmodule
